// ----- sv/vsa_pkg.sv -----
`timescale 1ns / 1ps
// vsa_pkg: shared types and constants for the vertex specular alpha pipeline.
// No dependencies; used by vsa_shade, vertex_specular_alpha and vsa_checker.
package vsa_pkg;

  // Input item: one vertex
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               last_vertex;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] spec_alpha;
    logic       last_out;
  } out_item_t;

  // Q1.14 three-component vector
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec_t;

  // Per-stage control that travels with an item
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIGHT_X = 3'd0,
    CFG_LIGHT_Y = 3'd1,
    CFG_LIGHT_Z = 3'd2,
    CFG_VIEW_X  = 3'd3,
    CFG_VIEW_Y  = 3'd4,
    CFG_VIEW_Z  = 3'd5
  } cfg_idx_t;

  localparam int CoordW = 24;

  // Reset light origin (-960.0, 1980.0, 96.0) in Q18.6
  localparam logic signed [CoordW-1:0] LIGHT_X_RST = -24'sd61440;
  localparam logic signed [CoordW-1:0] LIGHT_Y_RST = 24'sd126720;
  localparam logic signed [CoordW-1:0] LIGHT_Z_RST = 24'sd6144;
  localparam logic signed [CoordW-1:0] VIEW_RST    = 24'sd0;

  localparam logic [7:0] ALPHA_MAX = 8'd255;

  // Accept edge to result-strobe edge
  localparam int LATENCY = 33;

endpackage

// ----- sv/vsa_rsqrt.sv -----
`timescale 1ns / 1ps
// vsa_rsqrt: 16-stage bit-serial reciprocal square root, one result bit per stage.
// Finds the largest y with y*y*m <= 2^58 for m in [2^28, 2^30). Uses no package items.
module vsa_rsqrt (
  input  logic        clk,
  input  logic [29:0] m_in,
  output logic [15:0] y_out
);

  // Per stage: m, partial root y, A = y*y*m, B = y*m
  logic [29:0] m_r [16];
  logic [15:0] y_r [16];
  logic [58:0] a_r [16];
  logic [45:0] b_r [16];

  for (genvar j = 0; j < 16; j++) begin : g_step
    localparam int Bit = 15 - j;
    logic [29:0] m_in_s;
    logic [15:0] y_in_s;
    logic [58:0] a_in_s;
    logic [45:0] b_in_s;
    logic [62:0] cand;
    logic        take;

    if (j == 0) begin : g_first
      assign m_in_s = m_in;
      assign y_in_s = '0;
      assign a_in_s = '0;
      assign b_in_s = '0;
    end else begin : g_next
      assign m_in_s = m_r[j-1];
      assign y_in_s = y_r[j-1];
      assign a_in_s = a_r[j-1];
      assign b_in_s = b_r[j-1];
    end

    // (y + 2^b)^2 * m = A + 2^(b+1)*B + 4^b*m
    assign cand = {4'b0, a_in_s} + ({17'b0, b_in_s} << (Bit + 1))
                + ({33'b0, m_in_s} << (2 * Bit));
    assign take = (cand <= (63'd1 << 58));

    always_ff @(posedge clk) begin
      m_r[j] <= m_in_s;
      if (take) begin
        y_r[j] <= y_in_s | (16'd1 << Bit);
        a_r[j] <= cand[58:0];
        b_r[j] <= b_in_s + ({16'b0, m_in_s} << Bit);
      end else begin
        y_r[j] <= y_in_s;
        a_r[j] <= a_in_s;
        b_r[j] <= b_in_s;
      end
    end
  end

  assign y_out = y_r[15];

endmodule

// ----- sv/vsa_shade.sv -----
`timescale 1ns / 1ps
// vsa_shade: reflection about the normal, dot with view, fourth power and scale.
// Nine register stages. Depends on vsa_pkg.
module vsa_shade (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vsa_pkg::ctl_t         ctl_in,
  input  vsa_pkg::vec_t         l_in,
  input  vsa_pkg::vec_t         v_in,
  input  vsa_pkg::vec_t         n_in,
  output logic                  out_valid,
  output vsa_pkg::out_item_t    out_data
);

  vsa_pkg::ctl_t c_r [9];

  // Control travels with the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) c_r[k] <= '0;
    end else begin
      c_r[0] <= ctl_in;
      for (int k = 1; k < 9; k++) c_r[k] <= c_r[k-1];
    end
  end

  // S1: N.L products
  logic signed [31:0] pnl_x_r, pnl_y_r, pnl_z_r;
  vsa_pkg::vec_t n1_r, l1_r, v1_r;
  always_ff @(posedge clk) begin
    pnl_x_r <= n_in.x * l_in.x;
    pnl_y_r <= n_in.y * l_in.y;
    pnl_z_r <= n_in.z * l_in.z;
    n1_r <= n_in;
    l1_r <= l_in;
    v1_r <= v_in;
  end

  // S2: d = floor(N.L / 2^14)
  logic signed [33:0] nl_sum;
  logic signed [33:0] nl_sh;
  logic signed [19:0] d_r;
  vsa_pkg::vec_t n2_r, l2_r, v2_r;
  assign nl_sum = 34'(pnl_x_r) + 34'(pnl_y_r) + 34'(pnl_z_r);
  assign nl_sh  = nl_sum >>> 14;
  always_ff @(posedge clk) begin
    d_r  <= nl_sh[19:0];
    n2_r <= n1_r;
    l2_r <= l1_r;
    v2_r <= v1_r;
  end

  // S3: d*N products
  logic signed [35:0] pdn_x_r, pdn_y_r, pdn_z_r;
  vsa_pkg::vec_t l3_r, v3_r;
  always_ff @(posedge clk) begin
    pdn_x_r <= d_r * n2_r.x;
    pdn_y_r <= d_r * n2_r.y;
    pdn_z_r <= d_r * n2_r.z;
    l3_r <= l2_r;
    v3_r <= v2_r;
  end

  // S4: R = floor(2*d*N / 2^14) - L
  logic signed [35:0] sdn_x, sdn_y, sdn_z;
  logic signed [23:0] r_x_r, r_y_r, r_z_r;
  vsa_pkg::vec_t v4_r;
  assign sdn_x = pdn_x_r >>> 13;
  assign sdn_y = pdn_y_r >>> 13;
  assign sdn_z = pdn_z_r >>> 13;
  always_ff @(posedge clk) begin
    r_x_r <= sdn_x[23:0] - 24'(l3_r.x);
    r_y_r <= sdn_y[23:0] - 24'(l3_r.y);
    r_z_r <= sdn_z[23:0] - 24'(l3_r.z);
    v4_r  <= v3_r;
  end

  // S5: R.V products
  logic signed [39:0] prv_x_r, prv_y_r, prv_z_r;
  always_ff @(posedge clk) begin
    prv_x_r <= r_x_r * v4_r.x;
    prv_y_r <= r_y_r * v4_r.y;
    prv_z_r <= r_z_r * v4_r.z;
  end

  // S6: dot, sign and saturation flags, Q.14 value
  logic signed [41:0] dot;
  logic        neg_r, sat_r;
  logic [13:0] q_r;
  assign dot = 42'(prv_x_r) + 42'(prv_y_r) + 42'(prv_z_r);
  always_ff @(posedge clk) begin
    neg_r <= dot[41];
    sat_r <= !dot[41] && (|dot[40:28]);
    q_r   <= dot[27:14];
  end

  // S7: q^2
  logic [27:0] qq;
  logic [13:0] q2_r;
  logic        neg7_r, sat7_r;
  assign qq = q_r * q_r;
  always_ff @(posedge clk) begin
    q2_r   <= qq[27:14];
    neg7_r <= neg_r;
    sat7_r <= sat_r;
  end

  // S8: q^4
  logic [27:0] qqqq;
  logic [13:0] q4_r;
  logic        neg8_r, sat8_r;
  assign qqqq = q2_r * q2_r;
  always_ff @(posedge clk) begin
    q4_r   <= qqqq[27:14];
    neg8_r <= neg7_r;
    sat8_r <= sat7_r;
  end

  // S9: scale by 255, select zero or saturated value
  logic [21:0] scaled;
  logic [7:0]  alpha_r;
  assign scaled = q4_r * vsa_pkg::ALPHA_MAX;
  always_ff @(posedge clk) begin
    if (neg8_r)      alpha_r <= 8'd0;
    else if (sat8_r) alpha_r <= vsa_pkg::ALPHA_MAX;
    else             alpha_r <= scaled[21:14];
  end

  assign out_valid           = c_r[8].valid;
  assign out_data.spec_alpha = alpha_r;
  assign out_data.last_out   = c_r[8].last;

endmodule

// ----- sv/vertex_specular_alpha.sv -----
`timescale 1ns / 1ps
// vertex_specular_alpha: top level; config registers, differences, squared length,
// normalize, rsqrt, unit vectors. Depends on vsa_pkg, vsa_rsqrt, vsa_shade.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-------------------------------
//  input   | start, busy, in_data                   | taken when start && !busy
//  result  | out_valid, out_data                    | one-cycle strobe, no backpressure
//  config  | cfg_we, cfg_idx, cfg_wdata             | write when cfg_we high
//
// One vertex per cycle while busy is low; the delay from the accepting edge to the
// result strobe is set by the 16-stage rsqrt pipeline plus the arithmetic stages
// around it.
// rst_n is synchronous; it clears all valid bits and restores the light origin.
// busy is high only during reset. The receiver cannot stall; nothing in the
// pipeline ever waits.
module vertex_specular_alpha (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  vsa_pkg::in_item_t            in_data,
  output logic                         out_valid,
  output vsa_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [vsa_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [vsa_pkg::CoordW-1:0]   cfg_wdata
);

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               last;
    logic signed [24:0] dlx;
    logic signed [24:0] dly;
    logic signed [24:0] dlz;
    logic signed [24:0] dvx;
    logic signed [24:0] dvy;
    logic signed [24:0] dvz;
  } side_t;

  typedef struct packed {
    logic [4:0] shl;
    logic       zl;
    logic [4:0] shv;
    logic       zv;
  } nrm_t;

  localparam int SideN = 22;
  localparam int NrmN  = 18;

  logic signed [23:0] light_x_r, light_y_r, light_z_r;
  logic signed [23:0] view_x_r, view_y_r, view_z_r;

  assign busy = !rst_n;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r <= vsa_pkg::LIGHT_X_RST;
      light_y_r <= vsa_pkg::LIGHT_Y_RST;
      light_z_r <= vsa_pkg::LIGHT_Z_RST;
      view_x_r  <= vsa_pkg::VIEW_RST;
      view_y_r  <= vsa_pkg::VIEW_RST;
      view_z_r  <= vsa_pkg::VIEW_RST;
    end else if (cfg_we) begin
      case (vsa_pkg::cfg_idx_t'(cfg_idx))
        vsa_pkg::CFG_LIGHT_X: light_x_r <= $signed(cfg_wdata);
        vsa_pkg::CFG_LIGHT_Y: light_y_r <= $signed(cfg_wdata);
        vsa_pkg::CFG_LIGHT_Z: light_z_r <= $signed(cfg_wdata);
        vsa_pkg::CFG_VIEW_X:  view_x_r  <= $signed(cfg_wdata);
        vsa_pkg::CFG_VIEW_Y:  view_y_r  <= $signed(cfg_wdata);
        vsa_pkg::CFG_VIEW_Z:  view_z_r  <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Input register
  logic              in_vld_r;
  vsa_pkg::in_item_t in_r;
  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= start && !busy;
    in_r <= in_data;
  end

  // Side chain: differences, normal and flag travel alongside the math
  side_t      sd_r [SideN];
  logic [SideN-1:0] vld_r;
  side_t      sd_nxt;

  always_comb begin
    sd_nxt.nx   = in_r.norm_x;
    sd_nxt.ny   = in_r.norm_y;
    sd_nxt.nz   = in_r.norm_z;
    sd_nxt.last = in_r.last_vertex;
    sd_nxt.dlx  = 25'(light_x_r) - 25'(in_r.pos_x);
    sd_nxt.dly  = 25'(light_y_r) - 25'(in_r.pos_y);
    sd_nxt.dlz  = 25'(light_z_r) - 25'(in_r.pos_z);
    sd_nxt.dvx  = 25'(view_x_r) - 25'(in_r.pos_x);
    sd_nxt.dvy  = 25'(view_y_r) - 25'(in_r.pos_y);
    sd_nxt.dvz  = 25'(view_z_r) - 25'(in_r.pos_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[SideN-2:0], in_vld_r};
    sd_r[0] <= sd_nxt;
    for (int k = 1; k < SideN; k++) sd_r[k] <= sd_r[k-1];
  end

  // Magnitudes of a 25-bit difference
  function automatic logic [23:0] mag25(input logic signed [24:0] v);
    logic signed [24:0] a;
    a = v[24] ? -v : v;
    return a[23:0];
  endfunction

  // Squares
  logic [47:0] sq_r [6];
  always_ff @(posedge clk) begin
    sq_r[0] <= mag25(sd_r[0].dlx) * mag25(sd_r[0].dlx);
    sq_r[1] <= mag25(sd_r[0].dly) * mag25(sd_r[0].dly);
    sq_r[2] <= mag25(sd_r[0].dlz) * mag25(sd_r[0].dlz);
    sq_r[3] <= mag25(sd_r[0].dvx) * mag25(sd_r[0].dvx);
    sq_r[4] <= mag25(sd_r[0].dvy) * mag25(sd_r[0].dvy);
    sq_r[5] <= mag25(sd_r[0].dvz) * mag25(sd_r[0].dvz);
  end

  // Squared lengths
  logic [49:0] sl_r, sv_r;
  always_ff @(posedge clk) begin
    sl_r <= 50'(sq_r[0]) + 50'(sq_r[1]) + 50'(sq_r[2]);
    sv_r <= 50'(sq_r[3]) + 50'(sq_r[4]) + 50'(sq_r[5]);
  end

  // Leading one position; sh = msb/2, so t = sh - 14
  logic [5:0] kl, kv;
  always_comb begin
    kl = '0;
    kv = '0;
    for (int i = 0; i < 50; i++) begin
      if (sl_r[i]) kl = 6'(i);
      if (sv_r[i]) kv = 6'(i);
    end
  end

  logic [49:0] sl2_r, sv2_r;
  nrm_t        nm_r;
  always_ff @(posedge clk) begin
    sl2_r    <= sl_r;
    sv2_r    <= sv_r;
    nm_r.shl <= kl[5:1];
    nm_r.zl  <= (sl_r == '0);
    nm_r.shv <= kv[5:1];
    nm_r.zv  <= (sv_r == '0);
  end

  // Mantissa into [2^28, 2^30)
  function automatic logic [29:0] mant(input logic [49:0] s, input logic [4:0] sh);
    logic [49:0] t;
    if (sh >= 5'd14) t = s >> ({sh, 1'b0} - 6'd28);
    else             t = s << (6'd28 - {sh, 1'b0});
    return t[29:0];
  endfunction

  logic [29:0] ml_r, mv_r;
  nrm_t        nz_r [NrmN];
  always_ff @(posedge clk) begin
    ml_r <= mant(sl2_r, nm_r.shl);
    mv_r <= mant(sv2_r, nm_r.shv);
    nz_r[0] <= nm_r;
    for (int k = 1; k < NrmN; k++) nz_r[k] <= nz_r[k-1];
  end

  // Separate rsqrt pipelines for the light and view lengths
  logic [15:0] yl, yv;
  vsa_rsqrt u_rsqrt_l (.clk(clk), .m_in(ml_r), .y_out(yl));
  vsa_rsqrt u_rsqrt_v (.clk(clk), .m_in(mv_r), .y_out(yv));

  // d * y products
  logic signed [41:0] pl_r [3];
  logic signed [41:0] pv_r [3];
  always_ff @(posedge clk) begin
    pl_r[0] <= sd_r[20].dlx * $signed({1'b0, yl});
    pl_r[1] <= sd_r[20].dly * $signed({1'b0, yl});
    pl_r[2] <= sd_r[20].dlz * $signed({1'b0, yl});
    pv_r[0] <= sd_r[20].dvx * $signed({1'b0, yv});
    pv_r[1] <= sd_r[20].dvy * $signed({1'b0, yv});
    pv_r[2] <= sd_r[20].dvz * $signed({1'b0, yv});
  end

  // Unit vectors: floor(d*y / 2^(15+t)), zero vector for zero length
  function automatic logic signed [15:0] unit(input logic signed [41:0] p,
                                              input logic [4:0] sh, input logic z);
    logic signed [41:0] t;
    t = p >>> ({1'b0, sh} + 6'd1);
    return z ? 16'sd0 : t[15:0];
  endfunction

  vsa_pkg::vec_t lu_r, vu_r, nu_r;
  vsa_pkg::ctl_t cu_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cu_r <= '0;
    else begin
      cu_r.valid <= vld_r[21];
      cu_r.last  <= sd_r[21].last;
    end
    lu_r.x <= unit(pl_r[0], nz_r[17].shl, nz_r[17].zl);
    lu_r.y <= unit(pl_r[1], nz_r[17].shl, nz_r[17].zl);
    lu_r.z <= unit(pl_r[2], nz_r[17].shl, nz_r[17].zl);
    vu_r.x <= unit(pv_r[0], nz_r[17].shv, nz_r[17].zv);
    vu_r.y <= unit(pv_r[1], nz_r[17].shv, nz_r[17].zv);
    vu_r.z <= unit(pv_r[2], nz_r[17].shv, nz_r[17].zv);
    nu_r.x <= sd_r[21].nx;
    nu_r.y <= sd_r[21].ny;
    nu_r.z <= sd_r[21].nz;
  end

  // Reflection and power stages
  vsa_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (cu_r),
    .l_in     (lu_r),
    .v_in     (vu_r),
    .n_in     (nu_r),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

// ----- sv/vsa_checker.sv -----
`timescale 1ns / 1ps
// vsa_checker: port-level checks on vertex_specular_alpha, attached by bind.
// Depends on vsa_pkg.
module vsa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input vsa_pkg::in_item_t            in_data,
  input logic                         out_valid,
  input vsa_pkg::out_item_t           out_data
);

  // Every accepted item gives a result after the fixed latency
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(vsa_pkg::LATENCY) out_valid)
    else $error("accepted item produced no result");

  // No result without an item accepted at the matching edge
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, vsa_pkg::LATENCY))
    else $error("result without accepted item");

  // Last-vertex flag follows its item
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_out == $past(in_data.last_vertex, vsa_pkg::LATENCY)))
    else $error("last flag mismatch");

endmodule

bind vertex_specular_alpha vsa_checker u_vsa_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_data (out_data)
);
